// ===== rtl/core/fst_pkg.sv =====
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types and constants of the failover successor table: request and
// result records, stored record layout, state and status codes.
// ----------------------------------------------------------------------------
package fst_pkg;

	localparam int NUM_NODES   = 32;
	localparam int ORDER_SLOTS = 8;
	localparam int ID_W        = 8;
	localparam int NODE_W      = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int SLOT_W      = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
	localparam int SCAN_CNT_W  = $clog2(ORDER_SLOTS + 1);
	localparam int CNT_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	// Operation codes; the unused code behaves as a query.
	localparam logic [1:0] OP_INHERIT = 2'd0;
	localparam logic [1:0] OP_VERIFY  = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// Record states.
	localparam logic [1:0] REC_NONE      = 2'd0;
	localparam logic [1:0] REC_PROPOSED  = 2'd1;
	localparam logic [1:0] REC_CONFIRMED = 2'd2;
	localparam logic [1:0] REC_REVERTED  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_RANGE   = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_IDS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORDER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUORUM_MIN  = 2'd2;

	typedef logic [NODE_W-1:0] node_idx_t;

	typedef struct packed {
		logic [1:0]      op;
		logic [ID_W-1:0] failed_node;
		logic [ID_W-1:0] claimed_heir;
		logic [ID_W-1:0] vote_count;
	} fst_req_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] heir_id;
		logic [1:0]      record_state;
		logic [ID_W-1:0] votes_held;
	} fst_res_t;

	typedef struct packed {
		logic [1:0]      state;
		logic [ID_W-1:0] heir;
		logic [ID_W-1:0] votes;
	} rec_t;

	typedef struct packed {
		logic            hit;
		logic            miss;
		logic [ID_W-1:0] heir;
	} scan_t;

endpackage

// ===== rtl/core/failover_successor_table_core.sv =====
// ----------------------------------------------------------------------------
// failover_successor_table_core
// Keeps one succession record per failed node and serves inherit, verify and
// query commands against it.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a clock edge with start high and busy low. busy
//   stays high while an in-range command runs. done is high for exactly one
//   cycle with the result on res; the receiver takes every result as it comes.
//   An out-of-range node id is answered in the cycle after acceptance, with
//   no record read. Query, verify, and inherit on a proposed or confirmed
//   record finish after one registered record read. An inherit that searches
//   the order does the record read and then the search, which ends at the
//   first hit or when the usable slots are used up without a hit.
//   The search unit examines one order slot per cycle. busy is low in the done
//   cycle, so the next command can be taken there; no new command is taken
//   while the previous one is still running.
//   Configuration writes on cfg_valid/cfg_ready are always taken; the user must
//   issue them only while the block is idle, which the block does not enforce.
//   Reset clears all record states to none, order_ids and order_count to 0 and
//   quorum_min to 1; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module failover_successor_table_core import fst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  fst_req_t              req,
	output logic                  done,
	output fst_res_t              res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;

	logic [1:0]                  state_q;
	fst_req_t                    req_q;
	logic                        done_q;
	fst_res_t                    res_q;
	logic [ID_W*ORDER_SLOTS-1:0] order_ids_q;
	logic [CNT_W-1:0]            order_count_q;
	logic [ID_W-1:0]             quorum_q;

	logic       accept;
	logic       in_range;
	logic [CNT_W-1:0] limit;
	rec_t       rd_rec;
	scan_t      scan;
	logic       scan_go;
	logic       fin;
	logic [1:0] fin_status;
	rec_t       fin_rec;
	logic       wr_en;
	rec_t       wr_rec;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign in_range  = ({1'b0, req.failed_node} < 9'(NUM_NODES));
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign res       = res_q;
	assign limit     = (order_count_q > CNT_W'(ORDER_SLOTS)) ? CNT_W'(ORDER_SLOTS)
	                                                         : order_count_q;

	fst_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.failed_node[NODE_W-1:0]),
		.rd_rec  (rd_rec),
		.wr_en   (wr_en),
		.wr_addr (req_q.failed_node[NODE_W-1:0]),
		.wr_rec  (wr_rec)
	);

	fst_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (scan_go),
		.node      (req_q.failed_node),
		.order_ids (order_ids_q),
		.limit     (limit),
		.stat      (scan)
	);

	always_comb begin
		scan_go    = 1'b0;
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_rec    = rd_rec;
		wr_en      = 1'b0;
		wr_rec     = rd_rec;
		case (state_q)
			S_READ: begin
				case (req_q.op)
					OP_INHERIT: begin
						if (rd_rec.state == REC_PROPOSED || rd_rec.state == REC_CONFIRMED) begin
							fin = 1'b1;
						end else begin
							scan_go = 1'b1;
						end
					end
					OP_VERIFY: begin
						fin = 1'b1;
						if (rd_rec.state == REC_NONE || rd_rec.state == REC_REVERTED ||
						    rd_rec.heir != req_q.claimed_heir) begin
							fin_status = STAT_REFUSED;
						end else if (rd_rec.state == REC_PROPOSED) begin
							// Votes are stored even when they fall short of quorum.
							wr_en        = 1'b1;
							wr_rec.votes = req_q.vote_count;
							if (req_q.vote_count >= quorum_q) begin
								wr_rec.state = REC_CONFIRMED;
							end else begin
								fin_status = STAT_REFUSED;
							end
							fin_rec = wr_rec;
						end
					end
					default: begin
						fin = 1'b1;
						if (rd_rec.state == REC_NONE) begin
							fin_status = STAT_REFUSED;
						end
					end
				endcase
			end
			S_SCAN: begin
				if (scan.hit) begin
					fin          = 1'b1;
					wr_en        = 1'b1;
					wr_rec.state = REC_PROPOSED;
					wr_rec.heir  = scan.heir;
					wr_rec.votes = '0;
					fin_rec      = wr_rec;
				end else if (scan.miss) begin
					fin        = 1'b1;
					fin_status = STAT_REFUSED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_range) begin
							state_q <= S_READ;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					if (scan_go) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_SCAN: begin
					if (fin) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			if (!in_range) begin
				res_q.status       <= STAT_RANGE;
				res_q.heir_id      <= '0;
				res_q.record_state <= REC_NONE;
				res_q.votes_held   <= '0;
			end
		end else if (fin) begin
			// An empty record reports zero successor and votes.
			res_q.status       <= fin_status;
			res_q.record_state <= fin_rec.state;
			res_q.heir_id      <= (fin_rec.state == REC_NONE) ? '0 : fin_rec.heir;
			res_q.votes_held   <= (fin_rec.state == REC_NONE) ? '0 : fin_rec.votes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_ids_q   <= '0;
			order_count_q <= '0;
			quorum_q      <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORDER_IDS:   order_ids_q   <= cfg_data[ID_W*ORDER_SLOTS-1:0];
				CFG_ORDER_COUNT: order_count_q <= cfg_data[CNT_W-1:0];
				CFG_QUORUM_MIN:  quorum_q      <= cfg_data[ID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a command is still running");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result strobe without a preceding command");

	a_range_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_range) |=> (done && res.status == STAT_RANGE))
		else $error("out-of-range command not answered in one cycle");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.record_state == REC_NONE) |-> (res.heir_id == '0 && res.votes_held == '0))
		else $error("empty record reported with nonzero fields");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> fin)
		else $error("record write outside the finishing cycle");

endmodule

// ===== rtl/core/fst_scan.sv =====
// ----------------------------------------------------------------------------
// fst_scan
// Successor search unit: walks the proximity order one slot per cycle with a
// single compare; reports the first id unequal to the failed node, else a miss.
// ----------------------------------------------------------------------------
module fst_scan import fst_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    go,
	input  logic [ID_W-1:0]         node,
	input  logic [ID_W*ORDER_SLOTS-1:0] order_ids,
	input  logic [CNT_W-1:0]        limit,
	output scan_t                   stat
);

	logic                  active_q;
	logic [SCAN_CNT_W-1:0] idx_q;
	logic [ID_W-1:0]       cand;
	logic                  past_end;

	assign cand     = order_ids[idx_q[SLOT_W-1:0]*ID_W +: ID_W];
	assign past_end = (CNT_W'(idx_q) >= limit);

	always_comb begin
		stat.hit  = active_q && !past_end && (cand != node);
		stat.miss = active_q && past_end;
		stat.heir = cand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (go) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (active_q) begin
			if (stat.hit || stat.miss) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/fst_store.sv =====
// ----------------------------------------------------------------------------
// fst_store
// Succession record store: per-node state in flip-flops cleared at reset,
// successor and vote count in a memory, one registered read port and one
// write port.
// ----------------------------------------------------------------------------
module fst_store import fst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_en,
	input  node_idx_t rd_addr,
	output rec_t      rd_rec,
	input  logic      wr_en,
	input  node_idx_t wr_addr,
	input  rec_t      wr_rec
);

	logic [1:0]      state_q [NUM_NODES];
	logic [ID_W-1:0] heir_mem [NUM_NODES];
	logic [ID_W-1:0] votes_mem [NUM_NODES];
	logic [1:0]      rd_state_q;
	logic [ID_W-1:0] rd_heir_q;
	logic [ID_W-1:0] rd_votes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_NODES; i++) begin
				state_q[i] <= REC_NONE;
			end
			rd_state_q <= REC_NONE;
		end else begin
			if (wr_en) begin
				state_q[wr_addr] <= wr_rec.state;
			end
			if (rd_en) begin
				rd_state_q <= state_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heir_mem[wr_addr]  <= wr_rec.heir;
			votes_mem[wr_addr] <= wr_rec.votes;
		end
		if (rd_en) begin
			rd_heir_q  <= heir_mem[rd_addr];
			rd_votes_q <= votes_mem[rd_addr];
		end
	end

	always_comb begin
		rd_rec.state = rd_state_q;
		rd_rec.heir  = rd_heir_q;
		rd_rec.votes = rd_votes_q;
	end

endmodule
